### rtl/core/polygon_area_perimeter_top_defines.svh
// Assertion macros for the polygon area and perimeter checker.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef POLYGON_AREA_PERIMETER_TOP_DEFINES_SVH
`define POLYGON_AREA_PERIMETER_TOP_DEFINES_SVH

// same-cycle implication
`define PAP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pap_pkg.sv
// Shared types, constants and microcode program of the polygon area block.
// No dependencies.
`default_nettype none

package pap_pkg;

    localparam int CROSS_W = 59;
    localparam int LEN_W   = 35;
    localparam int AREA_W  = 58;
    localparam int PC_W    = 4;

    localparam logic [PC_W-1:0] ST_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] ST_EDGE  = 4'd1;
    localparam logic [PC_W-1:0] ST_MUL2  = 4'd2;
    localparam logic [PC_W-1:0] ST_MUL3  = 4'd3;
    localparam logic [PC_W-1:0] ST_MUL4  = 4'd4;
    localparam logic [PC_W-1:0] ST_RINIT = 4'd5;
    localparam logic [PC_W-1:0] ST_ROOT  = 4'd6;
    localparam logic [PC_W-1:0] ST_COMMIT = 4'd7;
    localparam logic [PC_W-1:0] ST_EMIT  = 4'd8;
    localparam logic [PC_W-1:0] ST_CLOSE = 4'd9;

    localparam logic [1:0] M_AXBY = 2'd0;
    localparam logic [1:0] M_AYBX = 2'd1;
    localparam logic [1:0] M_DXDX = 2'd2;
    localparam logic [1:0] M_DYDY = 2'd3;

    localparam logic [2:0] ACC_NONE   = 3'd0;
    localparam logic [2:0] ACC_T_LOAD = 3'd1;
    localparam logic [2:0] ACC_T_SUB  = 3'd2;
    localparam logic [2:0] ACC_R_LOAD = 3'd3;
    localparam logic [2:0] ACC_R_ADD  = 3'd4;

    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_LOOP     = 3'd1;
    localparam logic [2:0] C_DISPATCH = 3'd2;
    localparam logic [2:0] C_CLOSE    = 3'd3;
    localparam logic [2:0] C_EMIT     = 3'd4;

    typedef struct packed {
        logic            dif;
        logic            mul_en;
        logic [1:0]      msel;
        logic [2:0]      acc;
        logic            sq_step;
        logic            commit;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   accept;
        logic   close_load;
        logic   emit;
    } t_ctrl;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic fin;
        logic closing;
        logic sq_last;
        logic out_free;
    } t_stat;

    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            ST_WAIT:   w = '{1'b0, 1'b0, M_AXBY, ACC_NONE,   1'b0, 1'b0, C_DISPATCH, ST_EDGE};
            ST_EDGE:   w = '{1'b1, 1'b1, M_AXBY, ACC_NONE,   1'b0, 1'b0, C_NEXT,     ST_WAIT};
            ST_MUL2:   w = '{1'b0, 1'b1, M_AYBX, ACC_T_LOAD, 1'b0, 1'b0, C_NEXT,     ST_WAIT};
            ST_MUL3:   w = '{1'b0, 1'b1, M_DXDX, ACC_T_SUB,  1'b0, 1'b0, C_NEXT,     ST_WAIT};
            ST_MUL4:   w = '{1'b0, 1'b1, M_DYDY, ACC_R_LOAD, 1'b0, 1'b0, C_NEXT,     ST_WAIT};
            ST_RINIT:  w = '{1'b0, 1'b0, M_AXBY, ACC_R_ADD,  1'b0, 1'b0, C_NEXT,     ST_WAIT};
            ST_ROOT:   w = '{1'b0, 1'b0, M_AXBY, ACC_NONE,   1'b1, 1'b0, C_LOOP,     ST_ROOT};
            ST_COMMIT: w = '{1'b0, 1'b0, M_AXBY, ACC_NONE,   1'b0, 1'b1, C_CLOSE,    ST_EDGE};
            ST_EMIT:   w = '{1'b0, 1'b0, M_AXBY, ACC_NONE,   1'b0, 1'b0, C_EMIT,     ST_WAIT};
            ST_CLOSE:  w = '{1'b0, 1'b0, M_AXBY, ACC_NONE,   1'b0, 1'b0, C_CLOSE,    ST_EDGE};
            default:   w = '{1'b0, 1'b0, M_AXBY, ACC_NONE,   1'b0, 1'b0, C_DISPATCH, ST_EDGE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pap_ifs.sv
// Valid/ready channel interfaces: vertex requests in, result requests out.
// Depends on pap_pkg for the result field widths.
`default_nettype none

interface pap_vtx_if #(
    parameter int COORD_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         final_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output final_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input final_vertex,
                    output ready);
endinterface

interface pap_res_if import pap_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [AREA_W-1:0]   area_value;
    logic [LEN_W-1:0]    perimeter_value;
    logic                overflow_flag;

    modport source (output valid, output area_value, output perimeter_value,
                    output overflow_flag, input ready);
    modport sink   (input valid, input area_value, input perimeter_value,
                    input overflow_flag, output ready);
endinterface

`default_nettype wire

### rtl/core/pap_useq.sv
// Microcode sequencer: step counter, program table read, jump decisions.
// Depends on pap_pkg.
`default_nettype none

module pap_useq import pap_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;

    assign uw         = ucode_rom(r_pc);
    assign o_in_ready = (uw.cond == C_DISPATCH);

    always_comb begin
        o_ctrl.uw         = uw;
        o_ctrl.accept     = (uw.cond == C_DISPATCH) && i_in_valid;
        o_ctrl.close_load = (uw.cond == C_CLOSE) && i_stat.fin && !i_stat.closing;
        o_ctrl.emit       = (uw.cond == C_EMIT) && i_stat.out_free;
    end

    always_comb begin
        n_pc = r_pc;
        unique case (uw.cond)
            C_NEXT:  n_pc = r_pc + 1'b1;
            C_LOOP:  n_pc = i_stat.sq_last ? r_pc + 1'b1 : uw.target;
            C_DISPATCH: begin
                if (i_in_valid) begin
                    n_pc = (i_stat.count_zero || i_stat.count_full) ? ST_CLOSE : uw.target;
                end
            end
            C_CLOSE: begin
                if (i_stat.fin && !i_stat.closing) begin
                    n_pc = uw.target;
                end else if (i_stat.fin) begin
                    n_pc = ST_EMIT;
                end else begin
                    n_pc = ST_WAIT;
                end
            end
            C_EMIT:  n_pc = i_stat.out_free ? ST_WAIT : r_pc;
            default: n_pc = ST_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pap_dpath.sv
// Datapath: vertex registers, shared multiplier, root unit, sums, result register.
// Depends on pap_pkg; driven by pap_useq.
`default_nettype none

module pap_dpath import pap_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  t_ctrl                        i_ctrl,
    input  wire signed [COORD_BITS-1:0]  i_vtx_x,
    input  wire signed [COORD_BITS-1:0]  i_vtx_y,
    input  wire                          i_vtx_final,
    input  wire                          i_out_ready,
    output t_stat                        o_stat,
    output logic                         o_out_valid,
    output logic [AREA_W-1:0]            o_area,
    output logic [LEN_W-1:0]             o_perim,
    output logic                         o_ovf
);

    localparam int CW   = COORD_BITS;
    localparam int MW   = CW + 1;
    localparam int PW   = 2 * MW;
    localparam int TW   = 2 * CW + 1;
    localparam int SW   = ((TW > CROSS_W) ? TW : CROSS_W) + 1;
    localparam int NP   = CW + 1;
    localparam int REMW = NP + 2;
    localparam int SQW  = $clog2(NP + 1);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int LSW  = LEN_W + 1;

    localparam logic signed [SW-1:0] C_MAX = {{(SW-CROSS_W+1){1'b0}}, {(CROSS_W-1){1'b1}}};
    localparam logic signed [SW-1:0] C_MIN = {{(SW-CROSS_W+1){1'b1}}, {(CROSS_W-1){1'b0}}};

    t_uword uw;
    assign uw = i_ctrl.uw;

    logic signed [CW-1:0]      r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [CW-1:0]      r_ax, r_ay, r_bx, r_by;
    logic [CW-1:0]             r_dx, r_dy;
    logic signed [PW-1:0]      r_prod;
    logic signed [TW-1:0]      r_t;
    logic [PW-1:0]             r_rad;
    logic [REMW-1:0]           r_rem;
    logic [NP-1:0]             r_root;
    logic [SQW-1:0]            r_sq_cnt;
    logic signed [CROSS_W-1:0] r_cross;
    logic [LEN_W-1:0]          r_len;
    logic [CNTW-1:0]           r_count;
    logic                      r_overflow;
    logic                      r_fin;
    logic                      r_closing;
    logic                      r_out_valid;
    logic [AREA_W-1:0]         r_area;
    logic [LEN_W-1:0]          r_perim;
    logic                      r_ovf;

    logic signed [MW-1:0]      dx_s, dy_s;
    logic [MW-1:0]             dx_mag, dy_mag;
    logic signed [MW-1:0]      mul_a, mul_b;
    logic signed [PW-1:0]      mul_p;
    logic [1:0]                pair;
    logic [REMW-1:0]           rem_sh, trial;
    logic signed [SW-1:0]      cross_ext;
    logic signed [CROSS_W-1:0] n_cross;
    logic [LSW-1:0]            len_ext;
    logic [LEN_W-1:0]          n_len;
    logic [CROSS_W-1:0]        cross_mag;
    logic [AREA_W-1:0]         area_sat;
    logic                      count_zero, count_full;

    assign count_zero = (r_count == '0);
    assign count_full = (r_count == CNTW'(MAX_VERTICES));

    always_comb begin
        o_stat.count_zero = count_zero;
        o_stat.count_full = count_full;
        o_stat.fin        = r_fin;
        o_stat.closing    = r_closing;
        o_stat.sq_last    = (r_sq_cnt == SQW'(1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign dx_s   = {r_bx[CW-1], r_bx} - {r_ax[CW-1], r_ax};
    assign dy_s   = {r_by[CW-1], r_by} - {r_ay[CW-1], r_ay};
    assign dx_mag = dx_s[MW-1] ? (~dx_s + 1'b1) : dx_s;
    assign dy_mag = dy_s[MW-1] ? (~dy_s + 1'b1) : dy_s;

    always_comb begin
        unique case (uw.msel)
            M_AXBY: begin
                mul_a = {r_ax[CW-1], r_ax};
                mul_b = {r_by[CW-1], r_by};
            end
            M_AYBX: begin
                mul_a = {r_ay[CW-1], r_ay};
                mul_b = {r_bx[CW-1], r_bx};
            end
            M_DXDX: begin
                mul_a = {1'b0, r_dx};
                mul_b = {1'b0, r_dx};
            end
            M_DYDY: begin
                mul_a = {1'b0, r_dy};
                mul_b = {1'b0, r_dy};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // one radicand bit pair per step
    assign pair   = r_rad[PW-1 -: 2];
    assign rem_sh = {r_rem[REMW-3:0], pair};
    assign trial  = {r_root, 2'b01};

    // saturating sums
    assign cross_ext = {{(SW-CROSS_W){r_cross[CROSS_W-1]}}, r_cross}
                     + {{(SW-TW){r_t[TW-1]}}, r_t};
    always_comb begin
        if (cross_ext > C_MAX) begin
            n_cross = C_MAX[CROSS_W-1:0];
        end else if (cross_ext < C_MIN) begin
            n_cross = C_MIN[CROSS_W-1:0];
        end else begin
            n_cross = cross_ext[CROSS_W-1:0];
        end
    end

    assign len_ext = {1'b0, r_len} + {{(LSW-NP){1'b0}}, r_root};
    assign n_len   = len_ext[LEN_W] ? {LEN_W{1'b1}} : len_ext[LEN_W-1:0];

    assign cross_mag = r_cross[CROSS_W-1] ? (~r_cross + 1'b1) : r_cross;
    assign area_sat  = cross_mag[CROSS_W-1] ? {AREA_W{1'b1}} : cross_mag[AREA_W-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_cross     <= '0;
            r_len       <= '0;
            r_fin       <= 1'b0;
            r_closing   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sq_cnt    <= '0;
        end else begin
            if (i_ctrl.accept) begin
                r_fin     <= i_vtx_final;
                r_closing <= 1'b0;
                if (count_zero) begin
                    r_count <= CNTW'(1);
                end else if (!count_full) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_ctrl.close_load) begin
                r_closing <= 1'b1;
            end
            if (uw.acc == ACC_R_ADD) begin
                r_sq_cnt <= SQW'(NP);
            end else if (uw.sq_step) begin
                r_sq_cnt <= r_sq_cnt - 1'b1;
            end
            if (uw.commit) begin
                r_cross <= n_cross;
                r_len   <= n_len;
            end
            if (i_ctrl.emit) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_overflow  <= 1'b0;
                r_cross     <= '0;
                r_len       <= '0;
                r_fin       <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            if (count_zero) begin
                r_first_x <= i_vtx_x;
                r_first_y <= i_vtx_y;
                r_prev_x  <= i_vtx_x;
                r_prev_y  <= i_vtx_y;
            end else if (!count_full) begin
                r_ax     <= r_prev_x;
                r_ay     <= r_prev_y;
                r_bx     <= i_vtx_x;
                r_by     <= i_vtx_y;
                r_prev_x <= i_vtx_x;
                r_prev_y <= i_vtx_y;
            end
        end
        if (i_ctrl.close_load) begin
            r_ax <= r_prev_x;
            r_ay <= r_prev_y;
            r_bx <= r_first_x;
            r_by <= r_first_y;
        end
        if (uw.dif) begin
            r_dx <= dx_mag[CW-1:0];
            r_dy <= dy_mag[CW-1:0];
        end
        if (uw.mul_en) begin
            r_prod <= mul_p;
        end
        unique case (uw.acc)
            ACC_T_LOAD: r_t <= r_prod[TW-1:0];
            ACC_T_SUB:  r_t <= r_t - r_prod[TW-1:0];
            ACC_R_LOAD: r_rad <= r_prod;
            ACC_R_ADD: begin
                r_rad  <= r_rad + r_prod;
                r_rem  <= '0;
                r_root <= '0;
            end
            default: begin
            end
        endcase
        if (uw.sq_step) begin
            r_rad <= {r_rad[PW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[NP-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[NP-2:0], 1'b0};
            end
        end
        if (i_ctrl.emit) begin
            r_area  <= area_sat;
            r_perim <= r_len;
            r_ovf   <= r_overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_area      = r_area;
    assign o_perim     = r_perim;
    assign o_ovf       = r_ovf;

endmodule

`default_nettype wire

### rtl/core/polygon_area_perimeter_top.sv
// Polygon area and perimeter: takes one vertex request per item, COORD_BITS signed
// coordinates, and returns one result request on the vertex marked final. The
// first vertex of a polygon is only stored; every further vertex is accepted and
// then passes through four products on the single shared multiplier, the sum of the
// radicand, COORD_BITS+1 steps of the square-root loop at one radicand bit pair per
// cycle, and one commit into the sums, before the next vertex is taken. The final
// vertex adds the closing edge through the same steps and then loads the result
// register, which holds the result while the next polygon's vertices are taken;
// that load, and with it the vertex input, waits for as long as the previous result
// is still held unaccepted.
// Vertices beyond MAX_VERTICES are dropped and flagged in the result.
// Depends on pap_pkg, pap_ifs, pap_useq and pap_dpath.
`default_nettype none

module polygon_area_perimeter_top import pap_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pap_vtx_if.sink    i_vtx,
    pap_res_if.source  o_res
);

    t_ctrl ctrl;
    t_stat stat;
    logic  in_ready;

    pap_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    pap_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_vtx_x     (i_vtx.vertex_x),
        .i_vtx_y     (i_vtx.vertex_y),
        .i_vtx_final (i_vtx.final_vertex),
        .i_out_ready (o_res.ready),
        .o_stat      (stat),
        .o_out_valid (o_res.valid),
        .o_area      (o_res.area_value),
        .o_perim     (o_res.perimeter_value),
        .o_ovf       (o_res.overflow_flag)
    );

    assign i_vtx.ready = in_ready;

endmodule

`default_nettype wire

### rtl/core/pap_checker.sv
// Port-level checker for the polygon area block, bound to the top level.
// Depends on pap_pkg and polygon_area_perimeter_top_defines.svh.
`default_nettype none
`include "polygon_area_perimeter_top_defines.svh"

module pap_checker import pap_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [AREA_W-1:0] i_area,
    input wire [LEN_W-1:0]  i_perim
);

    `PAP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result request dropped while stalled")
    `PAP_ASSERT_SAME(a_ready_after_emit, $rose(i_out_valid), i_in_ready, "not ready for vertices after a result")
    `PAP_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "ready again right after a vertex")
    `PAP_ASSERT_SAME(a_zero_perim_zero_area, i_out_valid && (i_perim == '0), i_area == '0, "area without perimeter")

endmodule

bind polygon_area_perimeter_top pap_checker u_pap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_area      (o_res.area_value),
    .i_perim     (o_res.perimeter_value)
);

`default_nettype wire

### bench/pap_checker.sv
// Scoreboard for the polygon area and perimeter block: follows every accepted vertex
// request, predicts the result request of each polygon and compares it field by field.
// Depends on pap_pkg and the channel interfaces in pap_ifs.
module pap_scoreboard import pap_pkg::*; #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pap_vtx_if   i_vtx,
    pap_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint          SHOELACE_MAX = (longint'(1) << (CROSS_W - 1)) - 1;
    localparam longint          SHOELACE_MIN = -(longint'(1) << (CROSS_W - 1));
    localparam longint unsigned PERIM_MAX    = (64'd1 << LEN_W) - 1;
    localparam longint unsigned AREA_MAX     = (64'd1 << AREA_W) - 1;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [LEN_W-1:0]  perimeter;
        logic              overflow;
    } t_polygon_result;

    longint          first_x, first_y, prev_x, prev_y;
    longint          shoelace_sum;
    longint unsigned perim_sum;
    int              vtx_count;
    logic            dropped_vertex;
    t_polygon_result expected_polygons[$];
    t_polygon_result oldest;
    int              fail_total = 0;

    function automatic longint unsigned trunc_root(input longint unsigned radicand);
        longint unsigned rem, root, trial;
        int p;
        rem  = 0;
        root = 0;
        for (p = 31; p >= 0; p--) begin
            rem   = (rem << 2) | ((radicand >> (2 * p)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    task automatic clear_polygon();
        first_x        = 0;
        first_y        = 0;
        prev_x         = 0;
        prev_y         = 0;
        shoelace_sum   = 0;
        perim_sum      = 0;
        vtx_count      = 0;
        dropped_vertex = 1'b0;
    endtask

    task automatic fold_edge(input longint ax, input longint ay,
                             input longint bx, input longint by);
        longint          term, dx, dy;
        longint unsigned len;
        term = ax * by - ay * bx;
        dx   = (bx >= ax) ? bx - ax : ax - bx;
        dy   = (by >= ay) ? by - ay : ay - by;
        len  = trunc_root(dx * dx + dy * dy);
        if (term > 0 && shoelace_sum > SHOELACE_MAX - term) begin
            shoelace_sum = SHOELACE_MAX;
        end else if (term < 0 && shoelace_sum < SHOELACE_MIN - term) begin
            shoelace_sum = SHOELACE_MIN;
        end else begin
            shoelace_sum = shoelace_sum + term;
        end
        if (len > PERIM_MAX || perim_sum > PERIM_MAX - len) begin
            perim_sum = PERIM_MAX;
        end else begin
            perim_sum = perim_sum + len;
        end
    endtask

    task automatic take_vertex(input longint x, input longint y, input logic fin);
        longint unsigned area;
        t_polygon_result entry;
        if (vtx_count == 0) begin
            first_x   = x;
            first_y   = y;
            prev_x    = x;
            prev_y    = y;
            vtx_count = 1;
        end else if (vtx_count < MAX_VERTICES) begin
            fold_edge(prev_x, prev_y, x, y);
            prev_x    = x;
            prev_y    = y;
            vtx_count = vtx_count + 1;
        end else begin
            dropped_vertex = 1'b1;
        end
        if (fin) begin
            fold_edge(prev_x, prev_y, first_x, first_y);
            area = (shoelace_sum < 0) ? -shoelace_sum : shoelace_sum;
            if (area > AREA_MAX) begin
                area = AREA_MAX;
            end
            entry = '{area: area[AREA_W-1:0],
                      perimeter: perim_sum[LEN_W-1:0],
                      overflow: dropped_vertex};
            expected_polygons.insert(expected_polygons.size(), entry);
            clear_polygon();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_polygon();
            expected_polygons.delete();
        end else begin
            if (i_vtx.valid && i_vtx.ready) begin
                take_vertex(longint'(i_vtx.vertex_x), longint'(i_vtx.vertex_y),
                            i_vtx.final_vertex);
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_polygons.size() == 0) begin
                    fail_total = fail_total + 1;
                    if (fail_total <= 10) begin
                        $display("unexpected result request: area %0d perimeter %0d ovf %0b",
                                 i_res.area_value, i_res.perimeter_value,
                                 i_res.overflow_flag);
                    end
                end else begin
                    oldest = expected_polygons.pop_front();
                    if (i_res.area_value !== oldest.area
                            || i_res.perimeter_value !== oldest.perimeter
                            || i_res.overflow_flag !== oldest.overflow) begin
                        fail_total = fail_total + 1;
                        if (fail_total <= 10) begin
                            $display("result mismatch: area %0d/%0d perimeter %0d/%0d ovf %0b/%0b",
                                     oldest.area, i_res.area_value,
                                     oldest.perimeter, i_res.perimeter_value,
                                     oldest.overflow, i_res.overflow_flag);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_polygons.size();
    end

endmodule

### bench/polygon_area_perimeter_top_tb.sv
// Top of the polygon area and perimeter bench: clock, reset, vertex stimulus with
// random gaps, a result sink with random and long stalls, and the verdict.
// Depends on pap_pkg, pap_ifs, polygon_area_perimeter_top and pap_scoreboard.
module polygon_area_perimeter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_VERTICES    = 1024;
    localparam int COORD_BITS      = 24;
    localparam int RANDOM_ITEMS    = 1650;
    localparam int LONG_AFTER      = 400;
    localparam int PRESSURE_AFTER  = 25;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 100;
    localparam int CYCLE_LIMIT     = 600000;

    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count   = 0;
    int   vertices_sent = 0;
    int   results_taken = 0;
    int   source_calm   = 0;
    int   sink_calm     = 0;
    int   sink_hold;
    int   random_start;
    logic long_done     = 1'b0;

    pap_vtx_if #(.COORD_BITS(COORD_BITS)) vtx_ch ();
    pap_res_if                            res_ch ();

    polygon_area_perimeter_top #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx_ch),
        .o_res  (res_ch)
    );

    pap_scoreboard #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vtx       (vtx_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("polygon_area_perimeter_top_tb failed");
            $finish;
        end
    end

    function automatic logic signed [COORD_BITS-1:0] pick_coord();
        int v;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return COORD_BITS'(1);
                endcase
            end
            2, 3, 4: begin
                v = int'($urandom_range(0, 8191)) - 4096;
                return v[COORD_BITS-1:0];
            end
            default: begin
                v = $urandom();
                return v[COORD_BITS-1:0];
            end
        endcase
    endfunction

    function automatic int pick_polygon_size();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return 2;
            8, 9:    return $urandom_range(9, 40);
            default: return $urandom_range(3, 8);
        endcase
    endfunction

    task automatic send_vertex(input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y, input logic fin);
        int gap;
        if (source_calm > 0) begin
            gap         = 0;
            source_calm = source_calm - 1;
        end else begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 24) == 0) begin
                source_calm = $urandom_range(10, 60);
            end
        end
        if (gap > 0) begin
            vtx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vtx_ch.valid        <= 1'b1;
        vtx_ch.vertex_x     <= x;
        vtx_ch.vertex_y     <= y;
        vtx_ch.final_vertex <= fin;
        do @(posedge i_clk); while (!(vtx_ch.valid && vtx_ch.ready));
        vertices_sent = vertices_sent + 1;
    endtask

    task automatic send_polygon(input int size);
        int i;
        for (i = 0; i < size; i++) begin
            send_vertex(pick_coord(), pick_coord(), i == size - 1);
        end
    endtask

    initial begin
        vtx_ch.valid        <= 1'b0;
        vtx_ch.vertex_x     <= '0;
        vtx_ch.vertex_y     <= '0;
        vtx_ch.final_vertex <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_vertex('0, '0, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        send_vertex('0, '0, 1'b0);
        send_vertex(24'sd256, '0, 1'b0);
        send_vertex('0, 24'sd256, 1'b1);
        send_vertex('0, '0, 1'b0);
        send_vertex('0, 24'sd256, 1'b0);
        send_vertex(24'sd256, '0, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex('1, '1, 1'b0);
        send_vertex(24'sd1, '1, 1'b0);
        send_vertex('0, 24'sd1, 1'b1);

        // one oversized ring: the last two vertices are dropped, the final one among them
        random_start = vertices_sent;
        while (vertices_sent - random_start < RANDOM_ITEMS) begin
            if (!long_done && vertices_sent - random_start > LONG_AFTER) begin
                send_polygon(MAX_VERTICES + 2);
                long_done = 1'b1;
            end else begin
                send_polygon(pick_polygon_size());
            end
        end
        vtx_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("polygon_area_perimeter_top_tb passed");
        end else begin
            $display("polygon_area_perimeter_top_tb failed");
        end
        $finish;
    end

    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // hold off once long enough for the block to back up into the vertex channel
            if (results_taken == PRESSURE_AFTER) begin
                sink_hold = HOLD_OFF_CYCLES;
            end else if (sink_calm > 0) begin
                sink_hold = 0;
                sink_calm = sink_calm - 1;
            end else begin
                sink_hold = $urandom_range(0, 4);
                if ($urandom_range(0, 9) == 0) begin
                    sink_calm = $urandom_range(3, 12);
                end
            end
            if (sink_hold > 0) begin
                res_ch.ready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            results_taken = results_taken + 1;
        end
    end

endmodule

### polygon_area_perimeter_top.f
+incdir+rtl/core
rtl/core/pap_pkg.sv
rtl/core/pap_ifs.sv
rtl/core/pap_useq.sv
rtl/core/pap_dpath.sv
rtl/core/polygon_area_perimeter_top.sv
rtl/core/pap_checker.sv
bench/pap_checker.sv
bench/polygon_area_perimeter_top_tb.sv
